// File: sv/variable_reply_parser_assert.svh
// Assertion macros for the variable reply parser checker.
// Depends on nothing; included by the checker file.
`ifndef VARIABLE_REPLY_PARSER_ASSERT_SVH
`define VARIABLE_REPLY_PARSER_ASSERT_SVH

// same-cycle implication under async active-low reset
`define VRP_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("vrp assertion failed");

// next-cycle implication under async active-low reset
`define VRP_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("vrp assertion failed");

`endif

// File: sv/vrp_pkg.sv
// Package for the variable reply parser: transaction payload types and byte codes.
// No dependencies.
`timescale 1ns / 1ps

package vrp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} msg_t;

	typedef struct packed {
		logic        status;
		logic [31:0] timeout_value;
		logic [7:0]  log_level;
	} res_t;

	localparam logic [7:0] CODE_END     = 8'h00;
	localparam logic [7:0] CODE_TIMEOUT = 8'h01;
	localparam logic [7:0] CODE_LEVEL   = 8'h02;
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_ONE    = 8'h31;
	localparam logic [7:0] ASCII_FOUR   = 8'h34;
	localparam logic [7:0] ASCII_NINE   = 8'h39;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

endpackage

// File: sv/variable_reply_parser.sv
// Variable reply parser: byte-serial parse of timeout and log-level fields.
// One byte per cycle unless a held result is stalled; the result appears in the cycle after the last byte is accepted.
// Parse state and accumulators update in the accept cycle; the result register
// decouples the output, so msg_ready stays high unless a held result is stalled.
// Reset clears parse state, accumulators and result valid.
// Depends on vrp_pkg.
`timescale 1ns / 1ps

module variable_reply_parser #(
	parameter int TIMEOUT_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_ready,
	input  vrp_pkg::msg_t msg_data,
	output logic          res_valid,
	input  logic          res_ready,
	output vrp_pkg::res_t res_data
);
	import vrp_pkg::*;

	typedef enum logic [2:0] {
		ST_CODE,
		ST_TIMEOUT,
		ST_LEVEL,
		ST_LEVEND,
		ST_DONE,
		ST_ERROR
	} state_t;

	state_t                   state_q, state_nxt;
	logic [TIMEOUT_WIDTH-1:0] timeout_q, timeout_nxt;
	logic [7:0]               level_q, level_nxt;

	logic                     accept;
	logic [7:0]               digit;
	logic [TIMEOUT_WIDTH+3:0] prod;
	logic [8:0]               lvl_sum;
	logic [TIMEOUT_WIDTH+31:0] timeout_ext;
	logic                     ok;

	assign msg_ready = !res_valid || res_ready;
	assign accept    = msg_valid && msg_ready;

	assign digit   = msg_data.data_byte - ASCII_ZERO;
	// acc*10 + d as shifts and adds, four guard bits catch overflow
	assign prod    = ({4'b0, timeout_q} << 3) + ({4'b0, timeout_q} << 1)
		+ (TIMEOUT_WIDTH+4)'(digit[3:0]);
	assign lvl_sum = {1'b0, level_q} + 9'(digit[2:0]);

	always_comb begin
		state_nxt   = ST_ERROR;
		timeout_nxt = timeout_q;
		level_nxt   = level_q;
		case (state_q)
			ST_CODE: begin
				if (msg_data.data_byte == CODE_END) begin
					state_nxt = ST_DONE;
				end else if (msg_data.data_byte == CODE_TIMEOUT) begin
					state_nxt = ST_TIMEOUT;
				end else if (msg_data.data_byte == CODE_LEVEL) begin
					state_nxt = ST_LEVEL;
				end
			end
			ST_TIMEOUT: begin
				if (msg_data.data_byte == CODE_END) begin
					state_nxt = ST_CODE;
				end else if (msg_data.data_byte >= ASCII_ZERO &&
						msg_data.data_byte <= ASCII_NINE) begin
					state_nxt   = ST_TIMEOUT;
					timeout_nxt = (|prod[TIMEOUT_WIDTH+3:TIMEOUT_WIDTH]) ?
						{TIMEOUT_WIDTH{1'b1}} : prod[TIMEOUT_WIDTH-1:0];
				end
			end
			ST_LEVEL: begin
				if (msg_data.data_byte == CODE_END) begin
					state_nxt = ST_CODE;
				end else if (msg_data.data_byte >= ASCII_ONE &&
						msg_data.data_byte <= ASCII_FOUR) begin
					state_nxt = ST_LEVEND;
					level_nxt = lvl_sum[8] ? 8'hFF : lvl_sum[7:0];
				end
			end
			ST_LEVEND: begin
				if (msg_data.data_byte == CODE_END) begin
					state_nxt = ST_CODE;
				end
			end
			default: begin
				state_nxt = ST_ERROR;
			end
		endcase
	end

	// terminator seen and no error since is exactly the done state
	assign ok          = (state_nxt == ST_DONE);
	assign timeout_ext = {32'b0, timeout_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CODE;
			timeout_q <= '0;
			level_q   <= '0;
			res_valid <= 1'b0;
			res_data  <= '0;
		end else begin
			if (accept && msg_data.last_byte) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			if (accept) begin
				if (msg_data.last_byte) begin
					state_q                <= ST_CODE;
					timeout_q              <= '0;
					level_q                <= '0;
					res_data.status        <= ok ? STATUS_OK : STATUS_ERR;
					res_data.timeout_value <= ok ? timeout_ext[31:0] : 32'b0;
					res_data.log_level     <= ok ? level_nxt : 8'b0;
				end else begin
					state_q   <= state_nxt;
					timeout_q <= timeout_nxt;
					level_q   <= level_nxt;
				end
			end
		end
	end

endmodule

// File: sv/vrp_checker.sv
// Port-level checker for the variable reply parser, bound to the parser module.
// Depends on vrp_pkg and variable_reply_parser_assert.svh.
`timescale 1ns / 1ps
`include "variable_reply_parser_assert.svh"

module vrp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          msg_valid,
	input logic          msg_ready,
	input vrp_pkg::msg_t msg_data,
	input logic          res_valid,
	input logic          res_ready,
	input vrp_pkg::res_t res_data
);
	import vrp_pkg::*;

	`VRP_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data))
	`VRP_ASSERT_IMP(a_err_zero, clk, arst_n, res_valid && res_data.status == STATUS_ERR, res_data.timeout_value == 32'b0 && res_data.log_level == 8'b0)
	`VRP_ASSERT_IMP(a_res_cause, clk, arst_n, $rose(res_valid), $past(msg_valid && msg_ready && msg_data.last_byte))
	`VRP_ASSERT_IMP(a_no_stall, clk, arst_n, !res_valid, msg_ready)

endmodule

bind variable_reply_parser vrp_checker u_vrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg_valid),
	.msg_ready (msg_ready),
	.msg_data  (msg_data),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);
